[design/sm3_pkg.sv]
// Shared constants, command/status types and helper functions for the SM3 hasher.
package sm3_pkg;

  localparam int unsigned NumWords   = 8;
  localparam int unsigned WinWords   = 16;
  localparam int unsigned CountWidth = 61;

  localparam logic [31:0] SM3_IV [NumWords] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  localparam logic [31:0] T_EARLY    = 32'h79cc4519;
  localparam logic [31:0] T_LATE     = 32'h7a879d8a;
  // T_LATE rotated left by 16, the value it takes at round 16
  localparam logic [31:0] T_LATE_R16 = {T_LATE[15:0], T_LATE[31:16]};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      shift_en;
    byte_sel_e byte_sel;
    logic      count_inc;
    logic      round_en;
    logic      early;
    logic      t_switch;
    logic      fold;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_ge56;
    logic pos_zero;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

endpackage

[design/sm3_datapath.sv]
// SM3 datapath: message window, expansion, round unit, chaining value, digest output.
module sm3_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sm3_pkg::cmd_t       cmd_i,
  output sm3_pkg::sts_t       sts_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);

  logic [31:0] w_q [sm3_pkg::WinWords];
  logic [31:0] w_d [sm3_pkg::WinWords];
  logic [31:0] v_q [sm3_pkg::NumWords];
  logic [31:0] v_d [sm3_pkg::NumWords];
  logic [31:0] cv_q [sm3_pkg::NumWords];
  logic [31:0] cv_d [sm3_pkg::NumWords];
  logic [31:0] dig_q [sm3_pkg::NumWords];
  logic [31:0] dig_d [sm3_pkg::NumWords];
  logic [31:0] tj_q, tj_d;
  logic [5:0]  pos_q, pos_d;
  logic [sm3_pkg::CountWidth-1:0] count_q, count_d;
  logic        busy_q, busy_d;
  logic [2:0]  idx_q, idx_d;

  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [7:0]  len_byte;
  logic [7:0]  in_byte;
  logic [31:0] w_new;
  logic [31:0] a12, ss1, ss2, ff, gg, t1, t2;
  logic        out_acc;

  // Length field: bit count, big-endian, one byte per pad position 56..63
  assign bit_len  = {count_q, 3'b000};
  assign len_sel  = 3'd7 - pos_q[2:0];
  assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

  always_comb begin
    case (cmd_i.byte_sel)
      sm3_pkg::SEL_MSG:   in_byte = data_byte_i;
      sm3_pkg::SEL_PAD80: in_byte = sm3_pkg::PAD_BYTE;
      sm3_pkg::SEL_ZERO:  in_byte = 8'h00;
      sm3_pkg::SEL_LEN:   in_byte = len_byte;
      default:            in_byte = 8'h00;
    endcase
  end

  assign w_new = sm3_pkg::perm1(w_q[0] ^ w_q[7] ^ sm3_pkg::rol32(w_q[13], 15)) ^
                 sm3_pkg::rol32(w_q[3], 7) ^ w_q[10];

  assign a12 = sm3_pkg::rol32(v_q[0], 12);
  assign ss1 = sm3_pkg::rol32(a12 + v_q[4] + tj_q, 7);
  assign ss2 = ss1 ^ a12;
  assign ff  = cmd_i.early ? (v_q[0] ^ v_q[1] ^ v_q[2])
                           : ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
  assign gg  = cmd_i.early ? (v_q[4] ^ v_q[5] ^ v_q[6])
                           : ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
  assign t1  = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
  assign t2  = gg + v_q[7] + ss1 + w_q[0];

  assign out_acc = busy_q && out_ready_i;

  always_comb begin
    // window: bytes shift in at the bottom while filling, words shift during rounds
    for (int i = 0; i < sm3_pkg::WinWords; i++) begin
      w_d[i] = w_q[i];
    end
    if (cmd_i.shift_en) begin
      for (int i = 0; i < sm3_pkg::WinWords - 1; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[sm3_pkg::WinWords-1] = {w_q[sm3_pkg::WinWords-1][23:0], in_byte};
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < sm3_pkg::WinWords - 1; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[sm3_pkg::WinWords-1] = w_new;
    end

    if (cmd_i.round_en) begin
      v_d[0] = t1;
      v_d[1] = v_q[0];
      v_d[2] = sm3_pkg::rol32(v_q[1], 9);
      v_d[3] = v_q[2];
      v_d[4] = sm3_pkg::perm0(t2);
      v_d[5] = v_q[4];
      v_d[6] = sm3_pkg::rol32(v_q[5], 19);
      v_d[7] = v_q[6];
      tj_d   = cmd_i.t_switch ? sm3_pkg::T_LATE_R16 : sm3_pkg::rol32(tj_q, 1);
    end else begin
      for (int i = 0; i < sm3_pkg::NumWords; i++) begin
        v_d[i] = cv_q[i];
      end
      tj_d = sm3_pkg::T_EARLY;
    end

    for (int i = 0; i < sm3_pkg::NumWords; i++) begin
      cv_d[i]  = cv_q[i];
      dig_d[i] = dig_q[i];
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < sm3_pkg::NumWords; i++) begin
        cv_d[i] = cmd_i.finish ? sm3_pkg::SM3_IV[i] : (cv_q[i] ^ v_q[i]);
      end
    end
    if (cmd_i.fold && cmd_i.finish) begin
      for (int i = 0; i < sm3_pkg::NumWords; i++) begin
        dig_d[i] = cv_q[i] ^ v_q[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < sm3_pkg::NumWords - 1; i++) begin
        dig_d[i] = dig_q[i+1];
      end
    end

    pos_d   = cmd_i.shift_en ? pos_q + 6'd1 : pos_q;
    count_d = count_q;
    if (cmd_i.fold && cmd_i.finish) begin
      count_d = '0;
    end else if (cmd_i.count_inc) begin
      count_d = count_q + sm3_pkg::CountWidth'(1);
    end

    busy_d = busy_q;
    idx_d  = idx_q;
    if (cmd_i.fold && cmd_i.finish) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (out_acc) begin
      idx_d = idx_q + 3'd1;
      if (idx_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < sm3_pkg::NumWords; i++) begin
        cv_q[i] <= sm3_pkg::SM3_IV[i];
      end
    end else begin
      pos_q   <= pos_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      cv_q    <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    v_q   <= v_d;
    tj_q  <= tj_d;
    dig_q <= dig_d;
  end

  assign sts_o.pos_last = (pos_q == 6'd63);
  assign sts_o.pos_ge56 = (pos_q >= sm3_pkg::LEN_POS);
  assign sts_o.pos_zero = (pos_q == 6'd0);
  assign sts_o.out_busy = busy_q;

  assign out_valid_o   = busy_q;
  assign digest_word_o = dig_q[0];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

endmodule

[design/sm3_ctrl.sv]
// SM3 controller: byte intake, padding sequence, round counter and fold/finish control.
module sm3_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          byte_present_i,
  input  logic          message_end_i,
  input  sm3_pkg::sts_t sts_i,
  output sm3_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMP,
    S_FOLD,
    S_PAD
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic       pad_pend_q, pad_pend_d;
  logic       final_q, final_d;
  logic       first_q, first_d;
  logic       len_ok_q, len_ok_d;
  logic       ready;
  logic       len_eff;

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    pad_pend_d = pad_pend_q;
    final_d    = final_q;
    first_d    = first_q;
    len_ok_d   = len_ok_q;
    ready      = 1'b0;
    len_eff    = first_q ? !sts_i.pos_ge56 : len_ok_q;
    cmd_o      = '0;
    cmd_o.byte_sel = sm3_pkg::SEL_MSG;

    case (state_q)
      S_IDLE: begin
        // hold off an end beat until the previous digest has drained
        ready = !(sts_i.out_busy && message_end_i);
        if (in_valid_i && ready) begin
          if (byte_present_i) begin
            cmd_o.shift_en  = 1'b1;
            cmd_o.count_inc = 1'b1;
          end
          if (byte_present_i && sts_i.pos_last) begin
            state_d    = S_COMP;
            pad_pend_d = message_end_i;
            final_d    = 1'b0;
            first_d    = 1'b1;
            len_ok_d   = 1'b0;
          end else if (message_end_i) begin
            state_d    = S_PAD;
            pad_pend_d = 1'b1;
            first_d    = 1'b1;
            len_ok_d   = 1'b0;
          end
        end
      end
      S_COMP: begin
        cmd_o.round_en = 1'b1;
        cmd_o.early    = (rnd_q[5:4] == 2'b00);
        cmd_o.t_switch = (rnd_q == 6'd15);
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd_o.fold   = 1'b1;
        cmd_o.finish = final_q;
        if (final_q) begin
          state_d    = S_IDLE;
          final_d    = 1'b0;
          pad_pend_d = 1'b0;
        end else if (pad_pend_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        cmd_o.shift_en = 1'b1;
        if (first_q) begin
          cmd_o.byte_sel = sm3_pkg::SEL_PAD80;
        end else if (len_ok_q && sts_i.pos_ge56) begin
          cmd_o.byte_sel = sm3_pkg::SEL_LEN;
        end else begin
          cmd_o.byte_sel = sm3_pkg::SEL_ZERO;
        end
        first_d  = 1'b0;
        len_ok_d = len_eff;
        if (sts_i.pos_last) begin
          state_d  = S_COMP;
          final_d  = len_eff;
          len_ok_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rnd_q      <= '0;
      pad_pend_q <= 1'b0;
      final_q    <= 1'b0;
      first_q    <= 1'b0;
      len_ok_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      rnd_q      <= rnd_d;
      pad_pend_q <= pad_pend_d;
      final_q    <= final_d;
      first_q    <= first_d;
      len_ok_q   <= len_ok_d;
    end
  end

  a_fold_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP && rnd_q == 6'd63) |=> (state_q == S_FOLD))
    else $error("fold did not follow the last round");

  a_finish_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !sts_i.out_busy)
    else $error("digest overwritten while still draining");

  a_block_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP && rnd_q == 6'd0) |-> sts_i.pos_zero)
    else $error("compression started on a partial block");

  a_pad_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAD) |-> !sts_i.out_busy)
    else $error("padding while a digest is still pending");

endmodule

[design/sm3_message_hasher.sv]
// Top level of the SM3 message hasher: controller plus datapath.
// SM3 (256-bit) hasher taking one message byte per input beat. While a block
// fills, a beat is taken every cycle. The 64th byte of a block starts the
// compression: 64 rounds (one round per cycle through a single round
// unit, with the message expansion running alongside in a 16-word window)
// and then a fold of the result into the chaining value, all while input
// is stalled. A beat with message_end set finalizes the message: the padding
// bytes (0x80, zeros, 64-bit big-endian bit length) go into the same byte
// window one per cycle, so finishing costs the pad bytes of the last block
// plus a compression, and a further pad block and compression when fewer
// than nine bytes of room remain in the last block. The eight digest
// words then leave as eight output beats, word 0 first, from a separate
// digest register; the chaining value returns to the IV and the byte count
// to zero at once, so bytes of the next message are taken while the digest
// drains. Only an end beat waits for the previous digest to be fully taken.
// A beat with neither byte_present nor message_end is accepted and ignored.
module sm3_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sm3_pkg::cmd_t cmd;
  sm3_pkg::sts_t sts;

  // Sequence intake, padding and rounds
  sm3_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // Hold the window, chaining value, counters and the digest output stage
  sm3_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule
